// ===== rtl/core/amss_pkg.sv =====
// package: word types, configuration types, constants and helpers of the motif scanner
`default_nettype none

package amss_pkg;

    localparam int QPOS_W        = 24;
    localparam int RPOS_W        = 31;
    localparam int MOTIF_BASES_W = 64;
    localparam int MOTIF_CHARS   = MOTIF_BASES_W / 8;
    localparam int LEN_REQ_W     = 4;
    localparam int LEN_W         = 5;
    localparam int CFG_INDEX_W   = 3;
    localparam int MAX_MOTIF_DEF = 8;

    localparam logic [7:0] DASH_CODE = 8'h2D;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTIF_BASES    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTIF_LENGTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_START    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REF_START      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_LENGTH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_STRAND = 3'd5;

    // reset values
    localparam logic [MOTIF_BASES_W-1:0] MOTIF_BASES_RST  = 64'd18243;
    localparam logic [LEN_REQ_W-1:0]     MOTIF_LENGTH_RST = 4'd2;

    typedef struct packed {
        logic       first_column;
        logic [7:0] query_char;
        logic [7:0] ref_char;
    } t_in_word;

    typedef struct packed {
        logic [QPOS_W-1:0] query_offset;
        logic [RPOS_W-1:0] ref_offset;
    } t_out_word;

    typedef struct packed {
        logic [MOTIF_BASES_W-1:0] motif_bases;
        logic [LEN_REQ_W-1:0]     motif_length;
        logic [QPOS_W-1:0]        query_start;
        logic [RPOS_W-1:0]        ref_start;
        logic [QPOS_W-1:0]        read_length;
        logic                     reverse_strand;
    } t_cfg;

    typedef struct packed {
        logic      hit;
        t_out_word word;
    } t_track_res;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h20;
        end
        return v;
    endfunction

    // motif character k, zero beyond the packed characters
    function automatic logic [7:0] motif_char(input logic [MOTIF_BASES_W-1:0] bases,
                                              input logic [LEN_W-1:0] k);
        logic [7:0] v;
        v = 8'h00;
        if (k < LEN_W'(MOTIF_CHARS)) begin
            v = bases[8*k[2:0] +: 8];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/amss_track.sv =====
// module: position counters, column window and motif compare of the scanner
`default_nettype none

module amss_track
    import amss_pkg::*;
#(
    parameter int MAX_MOTIF = MAX_MOTIF_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_in_word   i_word,
    input  wire t_cfg       i_cfg,
    output t_track_res      o_res
);

    localparam int FILL_W = $clog2(MAX_MOTIF + 1);

    logic [QPOS_W-1:0] r_qpos, n_qpos;
    logic [RPOS_W-1:0] r_rpos, n_rpos;
    logic [7:0]        r_qwin [MAX_MOTIF];
    logic [7:0]        r_rwin [MAX_MOTIF];
    logic [7:0]        n_qwin [MAX_MOTIF];
    logic [7:0]        n_rwin [MAX_MOTIF];
    logic [FILL_W-1:0] r_fill, n_fill;

    logic [7:0]        w_qc, w_rc;
    logic [LEN_W-1:0]  w_len5;
    logic [FILL_W-1:0] w_len;
    logic [LEN_W-1:0]  w_gaps;
    logic [LEN_W-1:0]  w_cnt;
    logic              w_match;
    logic [LEN_W-1:0]  w_idx;
    logic [7:0]        w_mc;
    logic [QPOS_W-1:0] w_qs;
    logic [RPOS_W-1:0] w_rs;

    assign w_qc = upcase(i_word.query_char);
    assign w_rc = upcase(i_word.ref_char);

    // effective motif length, clamped to one .. MAX_MOTIF
    always_comb begin
        w_len5 = {1'b0, i_cfg.motif_length};
        if (w_len5 == '0) begin
            w_len5 = LEN_W'(1);
        end else if (w_len5 > LEN_W'(MAX_MOTIF)) begin
            w_len5 = LEN_W'(MAX_MOTIF);
        end
        w_len = w_len5[FILL_W-1:0];
    end

    // next window, positions and fill
    always_comb begin
        n_qwin[0] = w_qc;
        n_rwin[0] = w_rc;
        for (int s = 1; s < MAX_MOTIF; s++) begin
            n_qwin[s] = r_qwin[s-1];
            n_rwin[s] = r_rwin[s-1];
        end
        if (i_word.first_column) begin
            n_qpos = i_cfg.query_start;
            n_rpos = i_cfg.ref_start;
            n_fill = FILL_W'(1);
        end else begin
            n_qpos = r_qpos;
            n_rpos = r_rpos;
            n_fill = (r_fill < FILL_W'(MAX_MOTIF)) ? r_fill + FILL_W'(1) : r_fill;
        end
        if (w_qc != DASH_CODE) begin
            n_qpos = n_qpos + QPOS_W'(1);
        end
        if (w_rc != DASH_CODE) begin
            n_rpos = n_rpos + RPOS_W'(1);
        end
    end

    // slot s holds motif character len-1-s
    always_comb begin
        w_match = (n_fill >= w_len);
        for (int s = 0; s < MAX_MOTIF; s++) begin
            w_idx = w_len5 - LEN_W'(s) - LEN_W'(1);
            w_mc  = motif_char(i_cfg.motif_bases, w_idx);
            if (LEN_W'(s) < w_len5 && (n_qwin[s] != w_mc || n_rwin[s] != w_mc)) begin
                w_match = 1'b0;
            end
        end
    end

    // on a hit both rows equal the motif, so the non-gap count comes from the motif
    always_comb begin
        w_gaps = '0;
        for (int k = 0; k < MOTIF_CHARS; k++) begin
            if (LEN_W'(k) < w_len5 && i_cfg.motif_bases[8*k +: 8] == DASH_CODE) begin
                w_gaps = w_gaps + LEN_W'(1);
            end
        end
        w_cnt = w_len5 - w_gaps;
    end

    always_comb begin
        w_rs = n_rpos - RPOS_W'(w_cnt);
        w_qs = n_qpos - QPOS_W'(w_cnt);
        if (i_cfg.reverse_strand) begin
            w_qs = i_cfg.read_length - w_qs - QPOS_W'(w_len5);
        end
        o_res.hit               = w_match;
        o_res.word.query_offset = w_qs;
        o_res.word.ref_offset   = w_rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qpos <= '0;
            r_rpos <= '0;
            r_fill <= '0;
            for (int s = 0; s < MAX_MOTIF; s++) begin
                r_qwin[s] <= '0;
                r_rwin[s] <= '0;
            end
        end else if (i_step) begin
            r_qpos <= n_qpos;
            r_rpos <= n_rpos;
            r_fill <= n_fill;
            for (int s = 0; s < MAX_MOTIF; s++) begin
                r_qwin[s] <= n_qwin[s];
                r_rwin[s] <= n_rwin[s];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/aligned_motif_site_scanner_top.sv =====
// top level: motif site scanner over pairwise alignment columns, handshake and registers
// an accepted word is held in the input stage; its hit lands in the result stage
// throughput: one column word per cycle through the compare/offset stage, unless stalled
// reset: synchronous active-low i_rst_n empties both stages, zeroes positions and window,
// and restores the configuration registers to their defaults
`default_nettype none

module aligned_motif_site_scanner_top
    import amss_pkg::*;
#(
    parameter int MAX_MOTIF = MAX_MOTIF_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // column words
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_in_word                 i_in_data,
    // result words
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_out_word                     o_out_data,
    // configuration writes
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [MOTIF_BASES_W-1:0] i_cfg_data
);

    // input stage
    logic       r_in_valid;
    t_in_word   r_in_word;
    // result stage
    logic       r_out_valid;
    t_out_word  r_out_word;
    // configuration
    t_cfg       r_cfg;

    logic       w_in_fire;
    logic       w_step;
    t_track_res w_res;

    // the held column is processed when the result slot is free or being emptied;
    // a column with no hit still moves on so the window stays in order
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;
    assign o_cfg_ready = 1'b1;

    amss_track #(
        .MAX_MOTIF (MAX_MOTIF)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_word  (r_in_word),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_word <= i_in_data;
        end
    end

    // result register, loaded only on a motif hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_res.hit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.hit) begin
            r_out_word <= w_res.word;
        end
    end

    // configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motif_bases    <= MOTIF_BASES_RST;
            r_cfg.motif_length   <= MOTIF_LENGTH_RST;
            r_cfg.query_start    <= '0;
            r_cfg.ref_start      <= '0;
            r_cfg.read_length    <= '0;
            r_cfg.reverse_strand <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MOTIF_BASES: begin
                    r_cfg.motif_bases <= i_cfg_data;
                end
                CFG_MOTIF_LENGTH: begin
                    r_cfg.motif_length <= i_cfg_data[LEN_REQ_W-1:0];
                end
                CFG_QUERY_START: begin
                    r_cfg.query_start <= i_cfg_data[QPOS_W-1:0];
                end
                CFG_REF_START: begin
                    r_cfg.ref_start <= i_cfg_data[RPOS_W-1:0];
                end
                CFG_READ_LENGTH: begin
                    r_cfg.read_length <= i_cfg_data[QPOS_W-1:0];
                end
                CFG_REVERSE_STRAND: begin
                    r_cfg.reverse_strand <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // a stalled result word holds the column stage back
    a_stall_blocks_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_step)
        else $error("column processed while result word stalled");

    // a hit always shows up as a result word next cycle
    a_hit_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res.hit) |=> (r_out_valid && r_out_word == $past(w_res.word)))
        else $error("motif hit lost");

    // a processed column without hit leaves no result word behind
    a_miss_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !w_res.hit) |=> !r_out_valid)
        else $error("result word invented");

    // an accepted column word lands in the input stage
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_in_valid && r_in_word == $past(i_in_data)))
        else $error("column word not captured");

endmodule

`default_nettype wire

// ===== bench/amss_site_checker.sv =====
// checker: predicts motif sites from column words and compares the result words
`timescale 1ns / 1ps

module amss_site_checker
    import amss_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire t_in_word                 i_in_data,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire t_out_word                i_out_data,
    input  wire logic                     i_cfg_valid,
    input  wire logic                     i_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [MOTIF_BASES_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int WIN = MAX_MOTIF_DEF;

    // register copies
    logic [MOTIF_BASES_W-1:0] motif_bases;
    logic [LEN_REQ_W-1:0]     motif_length;
    logic [QPOS_W-1:0]        query_start;
    logic [RPOS_W-1:0]        ref_start;
    logic [QPOS_W-1:0]        read_length;
    logic                     reverse_strand;

    // scan state
    logic [QPOS_W-1:0] query_pos;
    logic [RPOS_W-1:0] ref_pos;
    logic [7:0]        query_win [WIN];
    logic [7:0]        ref_win [WIN];
    int                win_fill;

    t_out_word expected_sites [$];
    int        mismatches = 0;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < WIN; i++) begin
            query_win[i] = 8'h00;
            ref_win[i] = 8'h00;
        end
        win_fill = 0;
    endtask

    task automatic restore_defaults();
        motif_bases = MOTIF_BASES_RST;
        motif_length = MOTIF_LENGTH_RST;
        query_start = '0;
        ref_start = '0;
        read_length = '0;
        reverse_strand = 1'b0;
        query_pos = '0;
        ref_pos = '0;
        clear_window();
        expected_sites.delete();
    endtask

    task automatic load_register(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [MOTIF_BASES_W-1:0] data);
        case (idx)
            CFG_MOTIF_BASES:    motif_bases = data;
            CFG_MOTIF_LENGTH:   motif_length = data[LEN_REQ_W-1:0];
            CFG_QUERY_START:    query_start = data[QPOS_W-1:0];
            CFG_REF_START:      ref_start = data[RPOS_W-1:0];
            CFG_READ_LENGTH:    read_length = data[QPOS_W-1:0];
            CFG_REVERSE_STRAND: reverse_strand = data[0];
            default: ;
        endcase
    endtask

    // advance the scan by one column and queue the site it completes, if any
    task automatic predict_site(input t_in_word w);
        logic [7:0]        qc;
        logic [7:0]        rc;
        logic [7:0]        m;
        logic [QPOS_W-1:0] qs;
        logic [RPOS_W-1:0] rs;
        int                span;
        int                qbases;
        int                rbases;
        bit                hit;
        t_out_word         site;
        qc = fold_upper(w.query_char);
        rc = fold_upper(w.ref_char);
        span = (motif_length == 0) ? 1 : ((motif_length > WIN) ? WIN : int'(motif_length));
        if (w.first_column) begin
            query_pos = query_start;
            ref_pos = ref_start;
            clear_window();
        end
        for (int i = WIN - 1; i > 0; i--) begin
            query_win[i] = query_win[i-1];
            ref_win[i] = ref_win[i-1];
        end
        query_win[0] = qc;
        ref_win[0] = rc;
        if (win_fill < WIN) win_fill++;
        if (qc != DASH_CODE) query_pos = query_pos + 1'b1;
        if (rc != DASH_CODE) ref_pos = ref_pos + 1'b1;

        hit = (win_fill >= span);
        for (int i = 0; i < span; i++) begin
            m = motif_bases[8*i +: 8];
            if (query_win[span-1-i] != m || ref_win[span-1-i] != m) hit = 0;
        end
        if (hit) begin
            qbases = 0;
            rbases = 0;
            for (int i = 0; i < span; i++) begin
                if (query_win[i] != DASH_CODE) qbases++;
                if (ref_win[i] != DASH_CODE) rbases++;
            end
            qs = query_pos - QPOS_W'(qbases);
            rs = ref_pos - RPOS_W'(rbases);
            // reverse strand: mirror against the read length, wrapping on underflow
            if (reverse_strand) qs = read_length - qs - QPOS_W'(span);
            site.query_offset = qs;
            site.ref_offset = rs;
            expected_sites.insert(expected_sites.size(), site);
        end
    endtask

    task automatic check_site(input t_out_word got);
        t_out_word want;
        if (expected_sites.size() == 0) begin
            $display("%0t: result word with none expected, actual %h/%h",
                     $time, got.query_offset, got.ref_offset);
            mismatches++;
        end else begin
            want = expected_sites.pop_front();
            if (got.query_offset !== want.query_offset) begin
                $display("%0t: query_offset expected %h actual %h",
                         $time, want.query_offset, got.query_offset);
                mismatches++;
            end
            if (got.ref_offset !== want.ref_offset) begin
                $display("%0t: ref_offset expected %h actual %h",
                         $time, want.ref_offset, got.ref_offset);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            if (i_cfg_valid && i_cfg_ready) load_register(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) check_site(i_out_data);
            if (i_in_valid && i_in_ready) predict_site(i_in_data);
        end
        o_fail_count <= mismatches;
        o_pending <= expected_sites.size();
    end

endmodule

// ===== bench/tb_aligned_motif_site_scanner_top.sv =====
// testbench top: clock, reset, column and register stimulus, final verdict
`timescale 1ns / 1ps

module tb_aligned_motif_site_scanner_top;
    import amss_pkg::*;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    t_in_word                 i_in_data;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_out_word                o_out_data;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_INDEX_W-1:0]   i_cfg_index;
    logic [MOTIF_BASES_W-1:0] i_cfg_data;

    int fail_count;
    int sites_pending;

    // idle and stall switches, flipped per phase
    bit in_idle_on;
    bit out_stall_on;

    // stimulus-side view of the motif, used to plant hits
    logic [MOTIF_BASES_W-1:0] motif_now;
    int                       motif_span;
    int                       plant_pos;
    int                       read_left;

    aligned_motif_site_scanner_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // checker sits beside the block and only watches the channels
    amss_site_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (sites_pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: ready high except for random stall bursts, one update per falling edge
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_stall_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_in_word col(input bit first, input logic [7:0] q, input logic [7:0] r);
        t_in_word w;
        w.first_column = first;
        w.query_char = q;
        w.ref_char = r;
        return w;
    endfunction

    function automatic logic [7:0] pick_base();
        case ($urandom_range(0, 8))
            0: return "A";
            1: return "C";
            2: return "G";
            3: return "T";
            4: return "a";
            5: return "c";
            6: return "g";
            7: return "t";
            default: return DASH_CODE;
        endcase
    endfunction

    // letters may arrive in either case; the block folds them
    function automatic logic [7:0] maybe_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) return c | 8'h20;
        return c;
    endfunction

    // present one column word and hold it until the block takes it
    task automatic send_column(input t_in_word w);
        if (in_idle_on && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and wait until every predicted site has come out,
    // then wait on for columns still in flight that give no site
    task automatic drain_sites();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sites_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [MOTIF_BASES_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // full register set; only called with the block drained
    task automatic set_scan(input logic [63:0] bases, input logic [3:0] len,
                            input logic [23:0] qstart, input logic [30:0] rstart,
                            input logic [23:0] rlen, input bit rev);
        write_reg(CFG_MOTIF_BASES, bases);
        write_reg(CFG_MOTIF_LENGTH, 64'(len));
        write_reg(CFG_QUERY_START, 64'(qstart));
        write_reg(CFG_REF_START, 64'(rstart));
        write_reg(CFG_READ_LENGTH, 64'(rlen));
        write_reg(CFG_REVERSE_STRAND, 64'(rev));
        motif_now = bases;
        motif_span = (len == 0) ? 1 : ((len > 8) ? 8 : int'(len));
        plant_pos = 99;
    endtask

    // random column: mostly planted motifs and motif-like bases inside reads,
    // with stray restarts, corrupted plants and raw bytes as noise
    task automatic next_column(output t_in_word w);
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        w.first_column = 1'b0;
        if (read_left <= 0) begin
            w.first_column = 1'b1;
            read_left = $urandom_range(8, 60);
        end else if ($urandom_range(0, 49) == 0) begin
            w.first_column = 1'b1;
        end
        read_left--;
        if (plant_pos >= motif_span && r < 30) plant_pos = 0;
        if (plant_pos < motif_span) begin
            c = motif_now[8*plant_pos +: 8];
            w.query_char = maybe_lower(c);
            // now and then break the plant on the reference row
            w.ref_char = ($urandom_range(0, 19) == 0) ? pick_base() : maybe_lower(c);
            plant_pos++;
        end else if (r < 85) begin
            w.query_char = pick_base();
            w.ref_char = ($urandom_range(0, 2) == 0) ? pick_base() : w.query_char;
        end else begin
            w.query_char = 8'($urandom);
            w.ref_char = 8'($urandom);
        end
    endtask

    function automatic logic [63:0] random_motif();
        logic [63:0] m;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 8))
                0, 1: m[8*k +: 8] = "A";
                2, 3: m[8*k +: 8] = "C";
                4, 5: m[8*k +: 8] = "G";
                6, 7: m[8*k +: 8] = "T";
                default: m[8*k +: 8] = DASH_CODE;
            endcase
        end
        return m;
    endfunction

    initial begin : stimulus
        t_in_word    w;
        logic [3:0]  len;
        logic [23:0] qstart;
        logic [30:0] rstart;
        logic [23:0] rlen;
        int          wait_cycles;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MOTIF_BASES;
        i_cfg_data = '0;
        in_idle_on = 1'b1;
        out_stall_on = 1'b1;
        motif_now = MOTIF_BASES_RST;
        motif_span = 2;
        plant_pos = 99;
        read_left = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration: motif "CG", forward strand, starts at zero
        // columns before any first column count from zero
        send_column(col(0, "C", "C"));
        send_column(col(0, "G", "G"));
        // lowercase letters fold to the motif
        send_column(col(1, "a", "a"));
        send_column(col(0, "c", "c"));
        send_column(col(0, "g", "g"));
        // gap on one row spoils the match
        send_column(col(0, DASH_CODE, "T"));
        send_column(col(0, "C", "C"));
        send_column(col(0, "G", DASH_CODE));
        // byte extremes and the edges of the lowercase range
        send_column(col(0, 8'h00, 8'hFF));
        send_column(col(0, 8'hFF, 8'h00));
        send_column(col(0, 8'h60, 8'h7B));
        send_column(col(0, "z", "Z"));
        send_column(col(0, 8'h80, 8'h7F));
        // restart in the middle of a motif clears the window
        send_column(col(0, "C", "C"));
        send_column(col(1, "G", "G"));
        send_column(col(0, "C", "C"));
        send_column(col(0, "G", "G"));
        drain_sites();

        // gap inside the motif, positions wrapping, reverse strand mirror underflow
        set_scan({40'd0, "T", DASH_CODE, "A"}, 4'd3, 24'hFFFFFE, 31'h7FFFFFFE, 24'd1, 1'b1);
        send_column(col(1, "A", "A"));
        send_column(col(0, DASH_CODE, DASH_CODE));
        send_column(col(0, "T", "T"));
        send_column(col(0, "a", "a"));
        send_column(col(0, DASH_CODE, DASH_CODE));
        send_column(col(0, "t", "t"));
        send_column(col(0, "A", "A"));
        send_column(col(0, DASH_CODE, "C"));
        send_column(col(0, "T", "T"));
        drain_sites();

        // random phases, each under its own register set
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: len = 4'd1;
                1: len = 4'd8;
                2: len = 4'd0;     // zero length acts as one
                3: len = 4'd15;    // oversized length clamps to eight
                4: len = 4'd3;
                5: len = 4'd5;
                6: len = 4'd2;
                default: len = 4'd4;
            endcase
            case (p % 4)
                0: qstart = 24'h000000;
                1: qstart = 24'hFFFFFF;
                2: qstart = 24'hFFFFF8;
                default: qstart = 24'($urandom);
            endcase
            case (p % 3)
                0: rstart = 31'h00000000;
                1: rstart = 31'h7FFFFFFF;
                default: rstart = 31'($urandom);
            endcase
            case (p % 4)
                0: rlen = 24'hFFFFFF;
                1: rlen = 24'h000000;
                2: rlen = 24'($urandom);
                default: rlen = 24'($urandom_range(0, 40));
            endcase
            set_scan(random_motif(), len, qstart, rstart, rlen, p[0]);

            // phase 2 runs without input gaps, phase 3 without output stalls,
            // and the last two phases run flat out
            in_idle_on = (p < 6 && p != 2);
            out_stall_on = (p < 6 && p != 3);
            read_left = 0;

            for (int n = 0; n < 110; n++) begin
                // hold the sender until every pending site has come out
                if (p == 4 && n == 55) drain_sites();
                next_column(w);
                send_column(w);
            end
            drain_sites();
        end

        // wait out anything left, bounded
        wait_cycles = 0;
        while (sites_pending != 0 && wait_cycles < 2000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(negedge i_clk);

        if (fail_count == 0 && sites_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            if (sites_pending != 0) $display("%0d expected site words never came", sites_pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
